@@ design/terminal_line_editor_top_assert.svh @@
// Assertion macros for the terminal line editor checker.
// Depends on nothing; included by the checker file only.
`ifndef TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("terminal line editor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("terminal line editor check failed");

`endif

@@ design/tle_pkg.sv @@
// Shared types and constants of the terminal line editor.
// No dependencies; used by the top level, the port checker and the bench.
`default_nettype none

package tle_pkg;

    // Result channel codes carried on tuser.
    localparam logic [1:0] CH_ECHO = 2'd0;
    localparam logic [1:0] CH_LINE = 2'd1;
    localparam logic [1:0] CH_TERM = 2'd2;

    // Byte values the editor recognizes or emits.
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;
    localparam logic [7:0] BYTE_NUL   = 8'h00;

    localparam logic [5:0] MAX_CHARS_RESET = 6'd31;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ECHO  = 5'b00010,
        ST_RDREQ = 5'b00100,
        ST_LINE  = 5'b01000,
        ST_TERM  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        EK_CHAR  = 2'd0,
        EK_CR    = 2'd1,
        EK_ERASE = 2'd2
    } echo_kind_t;

endpackage

`default_nettype wire

@@ design/tle_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // Read data holds while no read is issued.
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/terminal_line_editor_top.sv @@
// Terminal line editor with echo: top level.
// Depends on tle_pkg and tle_ram.
//
//   Channel   Direction  Payload                                   Handshake
//   s_axis    in         tdata[7:0] rx_byte                        tvalid/tready
//   m_axis    out        tdata[7:0] data, tuser[1:0] channel, tlast tvalid/tready
//   cfg       in         cfg_wr_data[5:0] max_chars                cfg_wr_en
//
// A printable byte is taken while the sequencer is idle; the ECHO state then
// writes its echo to the output register. An erase produces three echo results
// (BS, SP, BS). A carriage return echoes CR and LF, reads each stored character
// (RDREQ) and outputs it (LINE), and ends with the terminator.
// The single read port of the line store sets the pace of the line walk.
// Reset (aresetn low, synchronous) empties the line and sets max_chars to 31.
// The line store itself is not cleared; only written entries are ever read.
// A stalled m_axis holds the result in the output register and the sequencer
// waits; a new item is taken whenever the sequencer is idle.
`default_nettype none

module terminal_line_editor_top #(
    parameter int LINE_CAPACITY = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input items.
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    // Result items.
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,   // [7:0] data
    output logic      [1:0] m_axis_tuser,   // [1:0] channel
    output logic            m_axis_tlast,   // last result of the input item
    // Configuration: max_chars.
    input  wire logic       cfg_wr_en,
    input  wire logic [5:0] cfg_wr_data
);

    import tle_pkg::*;

    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam logic [5:0] CAPACITY = 6'(LINE_CAPACITY);

    // Control state.
    state_t     state_reg, state_next;
    logic [5:0] count_reg, count_next;
    logic [5:0] max_chars_reg, max_chars_next;
    logic       out_valid_reg, out_valid_next;

    // Sequencer payload.
    echo_kind_t echo_kind_reg, echo_kind_next;
    logic [1:0] echo_idx_reg, echo_idx_next;
    logic [7:0] echo_byte_reg, echo_byte_next;
    logic [5:0] len_reg, len_next;
    logic [5:0] rd_idx_reg, rd_idx_next;

    // Output register payload.
    logic [7:0] out_data_reg, out_data_next;
    logic [1:0] out_chan_reg, out_chan_next;
    logic       out_last_reg, out_last_next;

    logic       in_accept;
    logic       out_free;
    logic [5:0] limit;
    logic       is_cr, is_erase, is_print;
    logic       ram_we, ram_re;
    logic [7:0] ram_rdata;
    logic [7:0] echo_data;
    logic       echo_last;
    logic       echo_done;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_chan_reg;
    assign m_axis_tlast  = out_last_reg;

    // The effective limit is max_chars clipped to the store size.
    assign limit = (max_chars_reg < CAPACITY) ? max_chars_reg : CAPACITY;

    assign is_cr    = (s_axis_tdata == BYTE_CR);
    assign is_erase = ((s_axis_tdata == BYTE_BS) || (s_axis_tdata == BYTE_DEL))
                      && (count_reg != 6'd0);
    assign is_print = (s_axis_tdata >= BYTE_SPACE) && (s_axis_tdata <= BYTE_TILDE)
                      && (count_reg < limit);

    // A character is written at the current count, only while the count is below
    // the clipped limit, so the address always lies inside the store.
    assign ram_we = in_accept && !is_cr && !is_erase && is_print;
    assign ram_re = (state_reg == ST_RDREQ);

    tle_ram #(
        .WIDTH(8),
        .DEPTH(LINE_CAPACITY)
    ) u_line_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(s_axis_tdata),
        .re   (ram_re),
        .raddr(rd_idx_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    // Echo sequences: a single character, CR LF, or BS SP BS.
    always_comb begin
        unique case (echo_kind_reg)
            EK_CHAR: begin
                echo_data = echo_byte_reg;
                echo_last = 1'b1;
                echo_done = 1'b1;
            end
            EK_CR: begin
                echo_data = (echo_idx_reg == 2'd0) ? BYTE_CR : BYTE_LF;
                echo_last = 1'b0;
                echo_done = (echo_idx_reg == 2'd1);
            end
            EK_ERASE: begin
                echo_data = (echo_idx_reg == 2'd1) ? BYTE_SPACE : BYTE_BS;
                echo_last = (echo_idx_reg == 2'd2);
                echo_done = (echo_idx_reg == 2'd2);
            end
            default: begin
                echo_data = BYTE_NUL;
                echo_last = 1'b1;
                echo_done = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        max_chars_next = cfg_wr_en ? cfg_wr_data : max_chars_reg;
        echo_kind_next = echo_kind_reg;
        echo_idx_next  = echo_idx_reg;
        echo_byte_next = echo_byte_reg;
        len_next       = len_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = m_axis_tready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        out_chan_next  = out_chan_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    echo_idx_next  = 2'd0;
                    echo_byte_next = s_axis_tdata;
                    priority if (is_cr) begin
                        echo_kind_next = EK_CR;
                        len_next       = count_reg;
                        rd_idx_next    = 6'd0;
                        count_next     = 6'd0;
                        state_next     = ST_ECHO;
                    end else if (is_erase) begin
                        echo_kind_next = EK_ERASE;
                        count_next     = count_reg - 6'd1;
                        state_next     = ST_ECHO;
                    end else if (is_print) begin
                        echo_kind_next = EK_CHAR;
                        count_next     = count_reg + 6'd1;
                        state_next     = ST_ECHO;
                    end else begin
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = echo_data;
                    out_chan_next  = CH_ECHO;
                    out_last_next  = echo_last;
                    echo_idx_next  = echo_idx_reg + 2'd1;
                    if (echo_done) begin
                        if (echo_kind_reg != EK_CR) begin
                            state_next = ST_IDLE;
                        end else if (len_reg == 6'd0) begin
                            state_next = ST_TERM;
                        end else begin
                            state_next = ST_RDREQ;
                        end
                    end
                end
            end
            ST_RDREQ: begin
                state_next = ST_LINE;
            end
            ST_LINE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = ram_rdata;
                    out_chan_next  = CH_LINE;
                    out_last_next  = 1'b0;
                    rd_idx_next    = rd_idx_reg + 6'd1;
                    state_next     = (rd_idx_reg + 6'd1 == len_reg) ? ST_TERM : ST_RDREQ;
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = BYTE_NUL;
                    out_chan_next  = CH_TERM;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= 6'd0;
            max_chars_reg <= MAX_CHARS_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_chars_reg <= max_chars_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        echo_kind_reg <= echo_kind_next;
        echo_idx_reg  <= echo_idx_next;
        echo_byte_reg <= echo_byte_next;
        len_reg       <= len_next;
        rd_idx_reg    <= rd_idx_next;
        out_data_reg  <= out_data_next;
        out_chan_reg  <= out_chan_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

@@ design/tle_checker.sv @@
// Port-level checker for the terminal line editor, bound to the top level.
// Depends on tle_pkg and terminal_line_editor_top_assert.svh.
`default_nettype none

`include "terminal_line_editor_top_assert.svh"

module tle_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    import tle_pkg::*;

    // A stalled result keeps its payload.
    `TLE_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // Only the three defined channels ever appear.
    `TLE_ASSERT_IMPLY(a_chan_legal, aclk, aresetn, m_axis_tvalid, m_axis_tuser == CH_ECHO || m_axis_tuser == CH_LINE || m_axis_tuser == CH_TERM)

    // The terminator is a zero byte and closes the item's results.
    `TLE_ASSERT_IMPLY(a_term_form, aclk, aresetn, m_axis_tvalid && m_axis_tuser == CH_TERM, m_axis_tdata == BYTE_NUL && m_axis_tlast)

    // A line byte is never the final result of a carriage return.
    `TLE_ASSERT_IMPLY(a_line_not_last, aclk, aresetn, m_axis_tvalid && m_axis_tuser == CH_LINE, !m_axis_tlast)

endmodule

bind terminal_line_editor_top tle_checker u_tle_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

@@ bench/tle_echo_checker.sv @@
// Line editor checker: follows both streams and the max_chars register,
// predicts every echo and line result, and compares them in order.
// Depends on tle_pkg for channel codes and byte values.
module tle_echo_checker
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic [1:0] m_axis_tuser,
    input  logic       m_axis_tlast,
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data,
    output int         fail_count,
    output int         pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] channel;
        logic [7:0] data;
        logic       last;
    } term_result_t;

    term_result_t expected_q[$];
    logic [7:0]   line_buf [LINE_CAPACITY];
    logic [5:0]   line_len;
    logic [5:0]   max_chars;
    int           errors = 0;

    task automatic push_result(input logic [1:0] ch, input logic [7:0] data, input logic last);
        term_result_t r;
        r.channel = ch;
        r.data    = data;
        r.last    = last;
        expected_q.push_back(r);
    endtask

    // Edits the predicted line for one received byte and queues what it echoes or emits.
    task automatic edit_line(input logic [7:0] rx);
        int limit;
        limit = (max_chars < LINE_CAPACITY) ? max_chars : LINE_CAPACITY;
        if (rx == BYTE_CR) begin
            push_result(CH_ECHO, BYTE_CR, 1'b0);
            push_result(CH_ECHO, BYTE_LF, 1'b0);
            for (int k = 0; k < line_len; k++) begin
                push_result(CH_LINE, line_buf[k], 1'b0);
            end
            push_result(CH_TERM, BYTE_NUL, 1'b1);
            line_len = '0;
        end else if ((rx == BYTE_BS || rx == BYTE_DEL) && line_len != 0) begin
            line_len = line_len - 1'b1;
            push_result(CH_ECHO, BYTE_BS, 1'b0);
            push_result(CH_ECHO, BYTE_SPACE, 1'b0);
            push_result(CH_ECHO, BYTE_BS, 1'b1);
        end else if (rx >= BYTE_SPACE && rx <= BYTE_TILDE && int'(line_len) < limit) begin
            line_buf[line_len] = rx;
            line_len = line_len + 1'b1;
            push_result(CH_ECHO, rx, 1'b1);
        end
    endtask

    task automatic compare_result();
        term_result_t exp;
        if (expected_q.size() == 0) begin
            $error("unexpected result: channel %0d data %h last %b",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
            errors++;
        end else begin
            exp = expected_q.pop_front();
            if (m_axis_tuser !== exp.channel) begin
                $error("channel: expected %0d, actual %0d", exp.channel, m_axis_tuser);
                errors++;
            end
            if (m_axis_tdata !== exp.data) begin
                $error("data: expected %h, actual %h", exp.data, m_axis_tdata);
                errors++;
            end
            if (m_axis_tlast !== exp.last) begin
                $error("last: expected %b, actual %b", exp.last, m_axis_tlast);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_q.delete();
            line_len  = '0;
            max_chars = MAX_CHARS_RESET;
        end else begin
            if (cfg_wr_en) begin
                max_chars = cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                edit_line(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                compare_result();
            end
        end
        fail_count      <= errors;
        pending_results <= expected_q.size();
    end

endmodule

@@ bench/terminal_line_editor_top_tb.sv @@
// Stimulus and verdict for the terminal line editor: types lines, erases and
// noise into the block under several max_chars settings, with random idling.
// Depends on tle_pkg, terminal_line_editor_top and tle_echo_checker.
module terminal_line_editor_top_tb;
    import tle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_CAPACITY = 32;
    // Cycles waited past the last result, enough for an ignored byte to clear.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400_000;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b1;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;
    logic       cfg_wr_en     = 1'b0;
    logic [5:0] cfg_wr_data   = '0;

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    int rx_count    = 0;   // Bytes sent that are not pure noise.
    int stall_left  = 0;
    bit idle_on     = 1'b1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    terminal_line_editor_top #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    tle_echo_checker #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    // Watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The terminal side pauses at random in bursts of random length, so
    // that stalls land on echoes, on the line walk and on the terminator alike.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Offers one byte and returns at the edge where it is taken. The valid
    // stays high on return so that back-to-back items leave no gap; an idle
    // burst, when one is drawn, comes before the next item is offered.
    task automatic send_byte(input logic [7:0] rx);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Lowers valid and waits until every predicted result has come back, then
    // waits out SETTLE_CYCLES in case the block is still busy with an ignored byte.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_limit(input logic [5:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Types one line of roughly the given length with erases and stray bytes
    // mixed in, and ends it with a carriage return.
    task automatic random_line(input int chars);
        int         typed;
        int         pick;
        logic [7:0] noise;
        typed = 0;
        while (typed < chars) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
                typed++;
                rx_count++;
            end else if (pick < 90) begin
                send_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
                rx_count++;
            end else begin
                // Stray bytes: control codes and the upper half, never an editing key.
                noise = 8'($urandom_range(0, 255));
                while (noise == BYTE_CR || noise == BYTE_BS || noise == BYTE_DEL ||
                       (noise >= BYTE_SPACE && noise <= BYTE_TILDE)) begin
                    noise = 8'($urandom_range(0, 255));
                end
                send_byte(noise);
            end
        end
        send_byte(BYTE_CR);
        rx_count++;
    endtask

    initial begin
        logic [5:0] phase_limit [6];
        int         phase_start;
        int         room;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset limit of 31 characters.
        send_byte(BYTE_CR);       // Carriage return on an empty line: the CR LF echo and the terminator.
        send_byte(BYTE_BS);       // Erase on an empty line yields nothing.
        send_byte(BYTE_DEL);
        send_byte(BYTE_SPACE);    // Lowest and highest printable bytes.
        send_byte(BYTE_TILDE);
        send_byte(8'h41);
        send_byte(BYTE_NUL);      // Other bytes leave the line alone.
        send_byte(8'h1F);
        send_byte(BYTE_LF);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(BYTE_BS);       // Both erase keys on a nonempty line.
        send_byte(BYTE_DEL);
        send_byte(BYTE_CR);       // Emits the one character left.

        // A zero limit ignores every printable byte.
        wait_idle();
        write_limit(6'd0);
        send_byte(8'h7A);
        send_byte(BYTE_CR);

        // Fill a short line, then one more byte finds it full.
        wait_idle();
        write_limit(6'd4);
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(8'h63);
        send_byte(8'h64);
        send_byte(8'h65);

        // Lower the limit below the count: typed bytes are ignored until erases make room,
        // and the stored characters survive.
        wait_idle();
        write_limit(6'd2);
        send_byte(8'h66);
        send_byte(BYTE_BS);
        send_byte(BYTE_BS);
        send_byte(BYTE_BS);
        send_byte(8'h67);
        send_byte(BYTE_CR);

        // Random part: one phase per limit setting, 63 and 1 among them.
        // A limit above the store size is clipped to LINE_CAPACITY. Random lines
        // stay short under a wide limit; the first phase fills the store instead.
        phase_limit = '{6'd63, 6'd1, 6'd32, 6'd61, 6'd0, MAX_CHARS_RESET};
        phase_limit[4] = 6'($urandom_range(0, 63));
        foreach (phase_limit[p]) begin
            wait_idle();
            // The final phase runs without any idling on either side.
            if (p == 5) begin
                idle_on = 1'b0;
            end
            write_limit(phase_limit[p]);
            room = (phase_limit[p] < LINE_CAPACITY) ? phase_limit[p] : LINE_CAPACITY;
            if (p == 0) begin
                // Type past the clipped limit so the store fills completely.
                repeat (LINE_CAPACITY + 2) begin
                    send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
                    rx_count++;
                end
                send_byte(BYTE_CR);
                rx_count++;
            end
            phase_start = rx_count;
            while (rx_count - phase_start < 4) begin
                random_line($urandom_range(0, (room < 8) ? room + 2 : 8));
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/tle_pkg.sv
design/tle_ram.sv
design/terminal_line_editor_top.sv
design/tle_checker.sv
bench/tle_echo_checker.sv
bench/terminal_line_editor_top_tb.sv
